// ===== hw/rtl/efe_pkg.sv =====
// ----------------------------------------------------------------------------
// efe_pkg: shared types and constants of the Elias-Fano encoder
// Holds the width of the low-width register, its reset value, the depth of
// the queue between front and back end, and the output beat states.
// ----------------------------------------------------------------------------
package efe_pkg;

  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_RESET   = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    BEAT_FIRST,
    BEAT_SECOND
  } beat_e;

endpackage

// ===== hw/rtl/efe_front.sv =====
// ----------------------------------------------------------------------------
// efe_front: id classification and list state
// Splits each id at the low width, codes the high part against the previous
// one, packs the low bits into words and builds one queue record per id.
// ----------------------------------------------------------------------------
module efe_front #(
  parameter int unsigned ID_BITS   = 20,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned REC_W     = 156
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [efe_pkg::CFG_W-1:0] cfg_wr_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ID_BITS-1:0]        cell_id_i,
  input  logic                      last_id_i,
  output logic                      push_o,
  input  logic                      push_ready_i,
  output logic [REC_W-1:0]          rec_o
);
  import efe_pkg::*;

  localparam int unsigned POS_W  = ID_BITS + 1;
  localparam int unsigned FILL_W = $clog2(WORD_BITS + 1);
  localparam int unsigned BUF_W  = WORD_BITS + ID_BITS;
  localparam int unsigned SUM_W  = $clog2(BUF_W + 1);
  localparam int unsigned LW_W   = $clog2(ID_BITS + 1);

  logic [CFG_W-1:0]   low_width_q;
  logic [ID_BITS-1:0] prev_high_q, prev_high_d;
  logic [POS_W-1:0]   ids_seen_q, ids_seen_d;
  logic [BUF_W-1:0]   bit_buffer_q, bit_buffer_d;
  logic [SUM_W-1:0]   buffer_fill_q, buffer_fill_d;

  logic [LW_W-1:0]    eff_width;
  logic [ID_BITS-1:0] lo, high, run;
  logic [POS_W-1:0]   pos;
  logic               order_err;
  logic [BUF_W-1:0]   combined, new_buf;
  logic [SUM_W-1:0]   fill_sum, new_fill;
  logic               full;
  logic [WORD_BITS-1:0] word1, word2;
  logic [FILL_W-1:0]  fill1, fill2;
  logic               valid1, two;

  assign in_ready_o = push_ready_i;
  assign push_o     = in_valid_i & push_ready_i;

  always_comb begin
    if (low_width_q == '0) begin
      eff_width = LW_W'(1);
    end else if (int'(low_width_q) > ID_BITS) begin
      eff_width = LW_W'(ID_BITS);
    end else begin
      eff_width = LW_W'(low_width_q);
    end
  end

  assign lo        = cell_id_i & ~({ID_BITS{1'b1}} << eff_width);
  assign high      = cell_id_i >> eff_width;
  assign order_err = high < prev_high_q;
  assign run       = high - prev_high_q;
  assign pos       = ids_seen_q + POS_W'(high);

  // buffer only holds bits below its fill, so OR-ing the new bits is safe
  assign combined = bit_buffer_q | (BUF_W'(lo) << buffer_fill_q);
  assign fill_sum = buffer_fill_q + SUM_W'(eff_width);
  assign full     = fill_sum >= SUM_W'(WORD_BITS);
  assign new_buf  = full ? (combined >> WORD_BITS) : combined;
  assign new_fill = full ? (fill_sum - SUM_W'(WORD_BITS)) : fill_sum;

  always_comb begin
    word1  = full ? combined[WORD_BITS-1:0] : '0;
    valid1 = full;
    fill1  = full ? FILL_W'(WORD_BITS) : '0;
    two    = 1'b0;
    word2  = '0;
    fill2  = '0;
    if (last_id_i && (new_fill != '0)) begin
      if (!full) begin
        word1  = new_buf[WORD_BITS-1:0];
        valid1 = 1'b1;
        fill1  = FILL_W'(new_fill);
      end else begin
        two   = 1'b1;
        word2 = new_buf[WORD_BITS-1:0];
        fill2 = FILL_W'(new_fill);
      end
    end
  end

  always_comb begin
    if (order_err) begin
      rec_o = {FILL_W'(0), WORD_BITS'(0), 1'b0, 1'b1, FILL_W'(0), 1'b0,
               WORD_BITS'(0), POS_W'(0), ID_BITS'(0), lo};
    end else begin
      rec_o = {fill2, word2, two, 1'b0, fill1, valid1, word1, pos, run, lo};
    end
  end

  always_comb begin
    prev_high_d   = prev_high_q;
    ids_seen_d    = ids_seen_q;
    bit_buffer_d  = bit_buffer_q;
    buffer_fill_d = buffer_fill_q;
    if (push_o && !order_err) begin
      if (last_id_i) begin
        prev_high_d   = '0;
        ids_seen_d    = '0;
        bit_buffer_d  = '0;
        buffer_fill_d = '0;
      end else begin
        prev_high_d   = high;
        ids_seen_d    = ids_seen_q + POS_W'(1);
        bit_buffer_d  = new_buf;
        buffer_fill_d = new_fill;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_width_q   <= CFG_W'(CFG_RESET);
      prev_high_q   <= '0;
      ids_seen_q    <= '0;
      bit_buffer_q  <= '0;
      buffer_fill_q <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        low_width_q <= cfg_wr_data_i;
      end
      prev_high_q   <= prev_high_d;
      ids_seen_q    <= ids_seen_d;
      bit_buffer_q  <= bit_buffer_d;
      buffer_fill_q <= buffer_fill_d;
    end
  end

endmodule

// ===== hw/rtl/efe_queue.sv =====
// ----------------------------------------------------------------------------
// efe_queue: record queue between front and back end
// Small FIFO of per-id records; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module efe_queue #(
  parameter int unsigned WIDTH = 156
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import efe_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/efe_back.sv =====
// ----------------------------------------------------------------------------
// efe_back: result output stage
// Holds one record in the output register and sends it as one result, or as
// two when the id both filled a word and closed a list with bits pending.
// ----------------------------------------------------------------------------
module efe_back #(
  parameter int unsigned ID_BITS   = 20,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned REC_W     = 156,
  parameter int unsigned OUT_W     = 104
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rec_valid_i,
  output logic             rec_pop_o,
  input  logic [REC_W-1:0] rec_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,
  output logic             m_axis_tuser_o,
  output logic             m_axis_tlast_o
);
  import efe_pkg::*;

  localparam int unsigned POS_W    = ID_BITS + 1;
  localparam int unsigned FILL_W   = $clog2(WORD_BITS + 1);
  localparam int unsigned DATA_LEN = 3 * ID_BITS + 1 + WORD_BITS + 1 + FILL_W;
  localparam int unsigned ERR_B    = DATA_LEN;
  localparam int unsigned TWO_B    = DATA_LEN + 1;
  localparam int unsigned W2_LO    = DATA_LEN + 2;
  localparam int unsigned F2_LO    = W2_LO + WORD_BITS;

  logic             out_valid_q, out_valid_d;
  beat_e            beat_q, beat_d;
  logic [REC_W-1:0] rec_q;
  logic             last_beat, advance, load;
  logic [DATA_LEN-1:0] data;

  assign last_beat = (beat_q == BEAT_SECOND) || !rec_q[TWO_B];
  assign advance   = !out_valid_q || (m_axis_tready_i && last_beat);
  assign load      = advance && rec_valid_i;
  assign rec_pop_o = load;

  // next state
  always_comb begin
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i && !last_beat) begin
      beat_d = BEAT_SECOND;
    end else if (advance) begin
      beat_d      = BEAT_FIRST;
      out_valid_d = rec_valid_i;
    end
  end

  // outputs
  always_comb begin
    unique case (beat_q)
      BEAT_FIRST: begin
        data           = rec_q[DATA_LEN-1:0];
        m_axis_tuser_o = rec_q[ERR_B];
        m_axis_tlast_o = !rec_q[TWO_B];
      end
      BEAT_SECOND: begin
        data           = {rec_q[F2_LO +: FILL_W], 1'b1, rec_q[W2_LO +: WORD_BITS],
                          POS_W'(0), ID_BITS'(0), ID_BITS'(0)};
        m_axis_tuser_o = 1'b0;
        m_axis_tlast_o = 1'b1;
      end
      default: begin
        data           = '0;
        m_axis_tuser_o = 1'b0;
        m_axis_tlast_o = 1'b1;
      end
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(data);

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= BEAT_FIRST;
    end else begin
      out_valid_q <= out_valid_d;
      beat_q      <= beat_d;
    end
  end

endmodule

// ===== hw/rtl/elias_fano_encoder.sv =====
// ----------------------------------------------------------------------------
// elias_fano_encoder: streaming Elias-Fano encoder for ascending id lists
//
// Channel    Dir  Handshake              Payload
// s_axis     in   tvalid/tready          tdata: cell_id; tlast: last_id
// m_axis     out  tvalid/tready          tdata: see port; tuser: order_error;
//                                        tlast: last result of the id
// cfg        in   cfg_wr_en_i            cfg_wr_data_i: low_width
//
// One id is accepted per cycle while the record queue has room.
// An id that completes a word and closes a list with bits pending gives two
// results and holds the output register until both have been taken.
// A two-entry record queue parts the id front end from the output register;
// s_axis_tready drops only while that queue is full.
// Reset clears the list state and sets low_width to 1.
// ----------------------------------------------------------------------------
module elias_fano_encoder #(
  parameter int unsigned ID_BITS   = 20,
  parameter int unsigned WORD_BITS = 32,
  localparam int unsigned IN_W     = ((ID_BITS + 7) / 8) * 8,
  localparam int unsigned DATA_LEN = 3 * ID_BITS + 1 + WORD_BITS + 1 +
                                     $clog2(WORD_BITS + 1),
  localparam int unsigned OUT_W    = ((DATA_LEN + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_en_i,
  input  logic [efe_pkg::CFG_W-1:0] cfg_wr_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // cell_id, zero padding
  input  logic [IN_W-1:0]           s_axis_tdata,
  input  logic                      s_axis_tlast,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // low_bits, high_zero_run, high_one_pos, packed_word, packed_valid,
  // packed_fill, zero padding
  output logic [OUT_W-1:0]          m_axis_tdata,
  // order_error
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast
);
  import efe_pkg::*;

  localparam int unsigned FILL_W = $clog2(WORD_BITS + 1);
  localparam int unsigned REC_W  = DATA_LEN + 2 + WORD_BITS + FILL_W;

  logic             push, push_ready, pop, pop_valid;
  logic [REC_W-1:0] push_rec, pop_rec;

  efe_front #(
    .ID_BITS   (ID_BITS),
    .WORD_BITS (WORD_BITS),
    .REC_W     (REC_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cell_id_i     (s_axis_tdata[ID_BITS-1:0]),
    .last_id_i     (s_axis_tlast),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .rec_o         (push_rec)
  );

  efe_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .push_data_i  (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_rec)
  );

  efe_back #(
    .ID_BITS   (ID_BITS),
    .WORD_BITS (WORD_BITS),
    .REC_W     (REC_W),
    .OUT_W     (OUT_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (pop_valid),
    .rec_pop_o       (pop),
    .rec_i           (pop_rec),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/efe_checker.sv =====
// ----------------------------------------------------------------------------
// efe_checker: port-level checks of the Elias-Fano encoder
// Watches the result stream for holding under stall and for consistent word, error and end marks.
// ----------------------------------------------------------------------------
module efe_checker #(
  parameter int unsigned ID_BITS   = 20,
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned OUT_W     = 104
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser,
  input logic             m_axis_tlast
);
  localparam int unsigned POS_W  = ID_BITS + 1;
  localparam int unsigned FILL_W = $clog2(WORD_BITS + 1);
  localparam int unsigned RUN_LO = ID_BITS;
  localparam int unsigned POS_LO = 2 * ID_BITS;
  localparam int unsigned WRD_LO = POS_LO + POS_W;
  localparam int unsigned VLD_B  = WRD_LO + WORD_BITS;
  localparam int unsigned FIL_LO = VLD_B + 1;

  logic [ID_BITS-1:0]   run;
  logic [POS_W-1:0]     pos;
  logic [WORD_BITS-1:0] word;
  logic                 pvalid;
  logic [FILL_W-1:0]    fill;

  assign run    = m_axis_tdata[RUN_LO +: ID_BITS];
  assign pos    = m_axis_tdata[POS_LO +: POS_W];
  assign word   = m_axis_tdata[WRD_LO +: WORD_BITS];
  assign pvalid = m_axis_tdata[VLD_B];
  assign fill   = m_axis_tdata[FIL_LO +: FILL_W];

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && run == '0 && pos == '0 &&
    word == '0 && !pvalid && fill == '0)
    else $error("order error result carries coded fields");

  a_no_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !pvalid |-> word == '0 && fill == '0)
    else $error("word fields set without a word");

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && pvalid |-> fill != '0 && fill <= FILL_W'(WORD_BITS))
    else $error("word fill out of range");

  a_first_of_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> pvalid && fill == FILL_W'(WORD_BITS) &&
    !m_axis_tuser)
    else $error("first of two results lacks a full word");

endmodule

bind elias_fano_encoder efe_checker #(
  .ID_BITS   (ID_BITS),
  .WORD_BITS (WORD_BITS),
  .OUT_W     (OUT_W)
) u_efe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
